[rtl/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared sizes, request and status codes, and controller/datapath bundles
// for the bounded double-ended queue with search.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int REQ_W  = 3;
    localparam int VAL_W  = 32;
    localparam int IDX_W  = 4;
    localparam int OUT_W  = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_POP_BACK   = 3'd1,
        REQ_PUSH_FRONT = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_FIND       = 3'd4,
        REQ_READ_AT    = 3'd5,
        REQ_SWAP       = 3'd6
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_PUSH_BACK,
        OP_POP_BACK,
        OP_PUSH_FRONT,
        OP_POP_FRONT,
        OP_RD_A,
        OP_RD_B,
        OP_CAPT,
        OP_WR_A,
        OP_WR_B,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_RESPOND
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             empty;
        logic             full;
        logic             idx_a_bad;
        logic             idx_b_bad;
        logic             scan_done;
    } t_stat;

    // Ring address of a position: head plus offset, wrapped at DEPTH.
    function automatic logic [ADDR_W-1:0] ring_addr(input logic [ADDR_W-1:0] head,
                                                    input logic [ADDR_W-1:0] pos);
        logic [ADDR_W:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (ADDR_W+1)'(DEPTH)) begin
            sum = sum - (ADDR_W+1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    // Head pointer stepped back by one, wrapped at DEPTH.
    function automatic logic [ADDR_W-1:0] ring_dec(input logic [ADDR_W-1:0] head);
        logic [ADDR_W-1:0] res;
        if (head == '0) begin
            res = ADDR_W'(DEPTH - 1);
        end else begin
            res = head - 1'b1;
        end
        return res;
    endfunction

endpackage

[rtl/bounded_deque_with_search.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded double-ended queue of up to 16 words held in a ring store, with
// push/pop at both ends, indexed read, swap and first-match search.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Word
//  --------  -------------------  ----------------------------------------------
//  request   start & !busy        i_req_type, i_value, i_index_a, i_index_b
//  result    o_done (one cycle)   o_data_out, o_found, o_found_position,
//                                 o_count_now, o_status
//
//  One request word at a time. After acceptance the sequencer steps through
//  EXEC and RESP for push and pop, adds RD_WAIT for read at, SW_B, SW_WA
//  and SW_WB for swap, and SCAN for find, which reads one stored element
//  per cycle through the single read port of the element store.
//  busy drops in the cycle the strobe shows, so the next word can be taken then.
//  The receiver cannot stall: the strobe shows for exactly one cycle, and the result word holds until the next result.
//  Synchronous active-low reset empties the queue (head and count to zero);
//  the element store itself is not cleared.
//
module bounded_deque_with_search (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [bdq_pkg::REQ_W-1:0] i_req_type,
    input  logic [bdq_pkg::VAL_W-1:0] i_value,
    input  logic [bdq_pkg::IDX_W-1:0] i_index_a,
    input  logic [bdq_pkg::IDX_W-1:0] i_index_b,
    output logic                      o_done,
    output logic [bdq_pkg::OUT_W-1:0] o_data_out,
    output logic                      o_found,
    output logic [bdq_pkg::IDX_W-1:0] o_found_position,
    output logic [bdq_pkg::CNT_W-1:0] o_count_now,
    output logic [1:0]                o_status
);

    import bdq_pkg::*;

    // Command from the sequencer, status back from the datapath.
    t_cmd  cmd;
    t_stat stat;

    bdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_done  (o_done)
    );

    // Datapath: ring store, pointers, scan and the result word registers,
    // which load in the same cycle the strobe register is set.
    bdq_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_req_type       (i_req_type),
        .i_value          (i_value),
        .i_index_a        (i_index_a),
        .i_index_b        (i_index_b),
        .o_stat           (stat),
        .o_data_out       (o_data_out),
        .o_found          (o_found),
        .o_found_position (o_found_position),
        .o_count_now      (o_count_now),
        .o_status         (o_status)
    );

endmodule

[rtl/bdq_ram.sv]
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bdq_ctrl.sv]
// ----------------------------------------------------------------------------
// bdq_ctrl
// Request sequencer: decodes a word, checks limits, steps the datapath
// through its operation and raises the result strobe.
// ----------------------------------------------------------------------------
module bdq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  bdq_pkg::t_stat i_stat,
    output bdq_pkg::t_cmd  o_cmd,
    output logic           o_done
);

    import bdq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_SW_B,
        S_SW_WA,
        S_SW_WB,
        S_SCAN,
        S_RESP
    } t_state;

    t_state  r_state, n_state;
    logic    r_busy,  n_busy;
    logic    r_done,  n_done;
    t_status r_status, n_status;
    t_op     op;

    always_comb begin
        n_state  = r_state;
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_status = r_status;
        op       = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    op       = OP_LATCH;
                    n_busy   = 1'b1;
                    n_status = ST_OK;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
                case (i_stat.req)
                    REQ_PUSH_BACK: begin
                        if (i_stat.full) n_status = ST_FULL;
                        else op = OP_PUSH_BACK;
                    end
                    REQ_PUSH_FRONT: begin
                        if (i_stat.full) n_status = ST_FULL;
                        else op = OP_PUSH_FRONT;
                    end
                    REQ_POP_BACK: begin
                        if (i_stat.empty) n_status = ST_EMPTY;
                        else op = OP_POP_BACK;
                    end
                    REQ_POP_FRONT: begin
                        if (i_stat.empty) n_status = ST_EMPTY;
                        else op = OP_POP_FRONT;
                    end
                    REQ_FIND: begin
                        op      = OP_SCAN_INIT;
                        n_state = S_SCAN;
                    end
                    REQ_READ_AT: begin
                        if (i_stat.idx_a_bad) begin
                            n_status = ST_RANGE;
                        end else begin
                            op      = OP_RD_A;
                            n_state = S_RD_WAIT;
                        end
                    end
                    REQ_SWAP: begin
                        if (i_stat.idx_a_bad || i_stat.idx_b_bad) begin
                            n_status = ST_RANGE;
                        end else begin
                            op      = OP_RD_A;
                            n_state = S_SW_B;
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_RD_WAIT: begin
                op      = OP_CAPT;
                n_state = S_RESP;
            end
            S_SW_B: begin
                op      = OP_RD_B;
                n_state = S_SW_WA;
            end
            S_SW_WA: begin
                op      = OP_WR_A;
                n_state = S_SW_WB;
            end
            S_SW_WB: begin
                op      = OP_WR_B;
                n_state = S_RESP;
            end
            S_SCAN: begin
                op = OP_SCAN;
                if (i_stat.scan_done) n_state = S_RESP;
            end
            S_RESP: begin
                op      = OP_RESPOND;
                n_done  = 1'b1;
                n_busy  = 1'b0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_done   <= n_done;
            r_status <= n_status;
        end
    end

    assign o_cmd.op     = op;
    assign o_cmd.status = r_status;
    assign busy         = r_busy;
    assign o_done       = r_done;

endmodule

[rtl/bdq_datapath.sv]
// ----------------------------------------------------------------------------
// bdq_datapath
// Ring store, head pointer, count, search scan and result registers.
// ----------------------------------------------------------------------------
module bdq_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bdq_pkg::t_cmd               i_cmd,
    input  logic [bdq_pkg::REQ_W-1:0]   i_req_type,
    input  logic [bdq_pkg::VAL_W-1:0]   i_value,
    input  logic [bdq_pkg::IDX_W-1:0]   i_index_a,
    input  logic [bdq_pkg::IDX_W-1:0]   i_index_b,
    output bdq_pkg::t_stat              o_stat,
    output logic [bdq_pkg::OUT_W-1:0]   o_data_out,
    output logic                        o_found,
    output logic [bdq_pkg::IDX_W-1:0]   o_found_position,
    output logic [bdq_pkg::CNT_W-1:0]   o_count_now,
    output logic [1:0]                  o_status
);

    import bdq_pkg::*;

    // Latched request
    logic [REQ_W-1:0]  r_req;
    logic [DATA_W-1:0] r_val;
    logic [IDX_W-1:0]  r_ia;
    logic [IDX_W-1:0]  r_ib;

    // Deque state
    logic [ADDR_W-1:0] r_head;
    logic [CNT_W-1:0]  r_count;

    // Scan and read holding
    logic [CNT_W-1:0]  r_scan_pos;
    logic              r_cmp_vld;
    logic [ADDR_W-1:0] r_cmp_pos;
    logic              r_hit;
    logic [ADDR_W-1:0] r_hit_pos;
    logic [DATA_W-1:0] r_data_a;

    // Result registers
    logic [OUT_W-1:0]  r_out_data;
    logic              r_out_found;
    logic [IDX_W-1:0]  r_out_fpos;
    logic [CNT_W-1:0]  r_out_count;
    logic [1:0]        r_out_status;

    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] addr_back;
    logic [ADDR_W-1:0] head_dec;
    logic [ADDR_W-1:0] addr_scan;
    logic              scan_more;
    logic              match;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    assign addr_a    = ring_addr(r_head, ADDR_W'(r_ia));
    assign addr_b    = ring_addr(r_head, ADDR_W'(r_ib));
    assign addr_back = ring_addr(r_head, r_count[ADDR_W-1:0]);
    assign head_dec  = ring_dec(r_head);
    assign addr_scan = ring_addr(r_head, r_scan_pos[ADDR_W-1:0]);
    assign scan_more = (r_scan_pos < r_count);
    assign match     = r_cmp_vld && (ram_rdata == r_val);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_a;
        ram_wdata = r_val;
        ram_raddr = addr_a;
        case (i_cmd.op)
            OP_PUSH_BACK: begin
                ram_we    = 1'b1;
                ram_waddr = addr_back;
            end
            OP_PUSH_FRONT: begin
                ram_we    = 1'b1;
                ram_waddr = head_dec;
            end
            OP_RD_B: begin
                ram_raddr = addr_b;
            end
            OP_WR_A: begin
                ram_we    = 1'b1;
                ram_waddr = addr_a;
                ram_wdata = ram_rdata;
            end
            OP_WR_B: begin
                ram_we    = 1'b1;
                ram_waddr = addr_b;
                ram_wdata = r_data_a;
            end
            OP_SCAN: begin
                ram_raddr = addr_scan;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Control state: pointer and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            case (i_cmd.op)
                OP_PUSH_BACK: begin
                    r_count <= r_count + 1'b1;
                end
                OP_PUSH_FRONT: begin
                    r_head  <= head_dec;
                    r_count <= r_count + 1'b1;
                end
                OP_POP_BACK: begin
                    r_count <= r_count - 1'b1;
                end
                OP_POP_FRONT: begin
                    r_head  <= ring_addr(r_head, ADDR_W'(1));
                    r_count <= r_count - 1'b1;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // Payload: request, scan and result registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LATCH: begin
                r_req <= i_req_type;
                r_val <= DATA_W'(i_value);
                r_ia  <= i_index_a;
                r_ib  <= i_index_b;
            end
            OP_RD_B, OP_CAPT: begin
                r_data_a <= ram_rdata;
            end
            OP_SCAN_INIT: begin
                r_scan_pos <= '0;
                r_cmp_vld  <= 1'b0;
                r_hit      <= 1'b0;
                r_hit_pos  <= '0;
            end
            OP_SCAN: begin
                // Issue the next position while comparing the previous read.
                r_cmp_vld <= scan_more;
                r_cmp_pos <= r_scan_pos[ADDR_W-1:0];
                if (scan_more) begin
                    r_scan_pos <= r_scan_pos + 1'b1;
                end
                if (match) begin
                    r_hit     <= 1'b1;
                    r_hit_pos <= r_cmp_pos;
                end
            end
            OP_RESPOND: begin
                r_out_count  <= r_count;
                r_out_status <= i_cmd.status;
                if (r_req == REQ_READ_AT && i_cmd.status == ST_OK) begin
                    r_out_data <= OUT_W'(r_data_a);
                end else begin
                    r_out_data <= '0;
                end
                if (r_req == REQ_FIND && r_hit) begin
                    r_out_found <= 1'b1;
                    r_out_fpos  <= IDX_W'(r_hit_pos);
                end else begin
                    r_out_found <= 1'b0;
                    r_out_fpos  <= '0;
                end
            end
            default: begin
                r_req <= r_req;
            end
        endcase
    end

    assign o_stat.req       = r_req;
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CNT_W'(DEPTH));
    assign o_stat.idx_a_bad = (CNT_W'(r_ia) >= r_count);
    assign o_stat.idx_b_bad = (CNT_W'(r_ib) >= r_count);
    assign o_stat.scan_done = match || !scan_more;

    assign o_data_out       = r_out_data;
    assign o_found          = r_out_found;
    assign o_found_position = r_out_fpos;
    assign o_count_now      = r_out_count;
    assign o_status         = r_out_status;

endmodule
